>>> rtl/vtc_pkg.sv
package vtc_pkg;

  localparam int VEL_W           = 16;
  localparam int MAXV_W          = 15;
  localparam int HI_W            = VEL_W - 1;
  localparam int CMP_W           = (HI_W > MAXV_W) ? HI_W : MAXV_W;
  localparam int IDX_W           = 8;
  localparam int COLOR_W         = 8;
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES      = IDX_W / STEPS_PER_STAGE;

  localparam logic [MAXV_W-1:0] MAXV_RESET = MAXV_W'(5);

  // Work item flowing down the divider: partial remainder, dividend bits still to
  // be shifted in, quotient bits so far, and the overflow / blanking flags.
  typedef struct packed {
    logic [MAXV_W-1:0] rem;
    logic [IDX_W-1:0]  low;
    logic [IDX_W-1:0]  quo;
    logic              sat;
    logic              blank;
  } vtc_work_t;

  typedef logic [3*COLOR_W-1:0] vtc_rgb_t;

  // Turbo map, each entry {red, green, blue}
  localparam vtc_rgb_t TURBO_LUT [2**IDX_W] = '{
    {8'd48,8'd18,8'd59},{8'd50,8'd21,8'd67},{8'd51,8'd24,8'd74},{8'd52,8'd27,8'd81},
    {8'd53,8'd30,8'd88},{8'd54,8'd33,8'd95},{8'd55,8'd36,8'd102},{8'd56,8'd39,8'd109},
    {8'd57,8'd42,8'd115},{8'd58,8'd45,8'd121},{8'd59,8'd47,8'd128},{8'd60,8'd50,8'd134},
    {8'd61,8'd53,8'd139},{8'd62,8'd56,8'd145},{8'd63,8'd59,8'd151},{8'd63,8'd62,8'd156},
    {8'd64,8'd64,8'd162},{8'd65,8'd67,8'd167},{8'd65,8'd70,8'd172},{8'd66,8'd73,8'd177},
    {8'd66,8'd75,8'd181},{8'd67,8'd78,8'd186},{8'd68,8'd81,8'd191},{8'd68,8'd84,8'd195},
    {8'd68,8'd86,8'd199},{8'd69,8'd89,8'd203},{8'd69,8'd92,8'd207},{8'd69,8'd94,8'd211},
    {8'd70,8'd97,8'd214},{8'd70,8'd100,8'd218},{8'd70,8'd102,8'd221},{8'd70,8'd105,8'd224},
    {8'd70,8'd107,8'd227},{8'd71,8'd110,8'd230},{8'd71,8'd113,8'd233},{8'd71,8'd115,8'd235},
    {8'd71,8'd118,8'd238},{8'd71,8'd120,8'd240},{8'd71,8'd123,8'd242},{8'd70,8'd125,8'd244},
    {8'd70,8'd128,8'd246},{8'd70,8'd130,8'd248},{8'd70,8'd133,8'd250},{8'd70,8'd135,8'd251},
    {8'd69,8'd138,8'd252},{8'd69,8'd140,8'd253},{8'd68,8'd143,8'd254},{8'd67,8'd145,8'd254},
    {8'd66,8'd148,8'd255},{8'd65,8'd150,8'd255},{8'd64,8'd153,8'd255},{8'd62,8'd155,8'd254},
    {8'd61,8'd158,8'd254},{8'd59,8'd160,8'd253},{8'd58,8'd163,8'd252},{8'd56,8'd165,8'd251},
    {8'd55,8'd168,8'd250},{8'd53,8'd171,8'd248},{8'd51,8'd173,8'd247},{8'd49,8'd175,8'd245},
    {8'd47,8'd178,8'd244},{8'd46,8'd180,8'd242},{8'd44,8'd183,8'd240},{8'd42,8'd185,8'd238},
    {8'd40,8'd188,8'd235},{8'd39,8'd190,8'd233},{8'd37,8'd192,8'd231},{8'd35,8'd195,8'd228},
    {8'd34,8'd197,8'd226},{8'd32,8'd199,8'd223},{8'd31,8'd201,8'd221},{8'd30,8'd203,8'd218},
    {8'd28,8'd205,8'd216},{8'd27,8'd208,8'd213},{8'd26,8'd210,8'd210},{8'd26,8'd212,8'd208},
    {8'd25,8'd213,8'd205},{8'd24,8'd215,8'd202},{8'd24,8'd217,8'd200},{8'd24,8'd219,8'd197},
    {8'd24,8'd221,8'd194},{8'd24,8'd222,8'd192},{8'd24,8'd224,8'd189},{8'd25,8'd226,8'd187},
    {8'd25,8'd227,8'd185},{8'd26,8'd228,8'd182},{8'd28,8'd230,8'd180},{8'd29,8'd231,8'd178},
    {8'd31,8'd233,8'd175},{8'd32,8'd234,8'd172},{8'd34,8'd235,8'd170},{8'd37,8'd236,8'd167},
    {8'd39,8'd238,8'd164},{8'd42,8'd239,8'd161},{8'd44,8'd240,8'd158},{8'd47,8'd241,8'd155},
    {8'd50,8'd242,8'd152},{8'd53,8'd243,8'd148},{8'd56,8'd244,8'd145},{8'd60,8'd245,8'd142},
    {8'd63,8'd246,8'd138},{8'd67,8'd247,8'd135},{8'd70,8'd248,8'd132},{8'd74,8'd248,8'd128},
    {8'd78,8'd249,8'd125},{8'd82,8'd250,8'd122},{8'd85,8'd250,8'd118},{8'd89,8'd251,8'd115},
    {8'd93,8'd252,8'd111},{8'd97,8'd252,8'd108},{8'd101,8'd253,8'd105},{8'd105,8'd253,8'd102},
    {8'd109,8'd254,8'd98},{8'd113,8'd254,8'd95},{8'd117,8'd254,8'd92},{8'd121,8'd254,8'd89},
    {8'd125,8'd255,8'd86},{8'd128,8'd255,8'd83},{8'd132,8'd255,8'd81},{8'd136,8'd255,8'd78},
    {8'd139,8'd255,8'd75},{8'd143,8'd255,8'd73},{8'd146,8'd255,8'd71},{8'd150,8'd254,8'd68},
    {8'd153,8'd254,8'd66},{8'd156,8'd254,8'd64},{8'd159,8'd253,8'd63},{8'd161,8'd253,8'd61},
    {8'd164,8'd252,8'd60},{8'd167,8'd252,8'd58},{8'd169,8'd251,8'd57},{8'd172,8'd251,8'd56},
    {8'd175,8'd250,8'd55},{8'd177,8'd249,8'd54},{8'd180,8'd248,8'd54},{8'd183,8'd247,8'd53},
    {8'd185,8'd246,8'd53},{8'd188,8'd245,8'd52},{8'd190,8'd244,8'd52},{8'd193,8'd243,8'd52},
    {8'd195,8'd241,8'd52},{8'd198,8'd240,8'd52},{8'd200,8'd239,8'd52},{8'd203,8'd237,8'd52},
    {8'd205,8'd236,8'd52},{8'd208,8'd234,8'd52},{8'd210,8'd233,8'd53},{8'd212,8'd231,8'd53},
    {8'd215,8'd229,8'd53},{8'd217,8'd228,8'd54},{8'd219,8'd226,8'd54},{8'd221,8'd224,8'd55},
    {8'd223,8'd223,8'd55},{8'd225,8'd221,8'd55},{8'd227,8'd219,8'd56},{8'd229,8'd217,8'd56},
    {8'd231,8'd215,8'd57},{8'd233,8'd213,8'd57},{8'd235,8'd211,8'd57},{8'd236,8'd209,8'd58},
    {8'd238,8'd207,8'd58},{8'd239,8'd205,8'd58},{8'd241,8'd203,8'd58},{8'd242,8'd201,8'd58},
    {8'd244,8'd199,8'd58},{8'd245,8'd197,8'd58},{8'd246,8'd195,8'd58},{8'd247,8'd193,8'd58},
    {8'd248,8'd190,8'd57},{8'd249,8'd188,8'd57},{8'd250,8'd186,8'd57},{8'd251,8'd184,8'd56},
    {8'd251,8'd182,8'd55},{8'd252,8'd179,8'd54},{8'd252,8'd177,8'd54},{8'd253,8'd174,8'd53},
    {8'd253,8'd172,8'd52},{8'd254,8'd169,8'd51},{8'd254,8'd167,8'd50},{8'd254,8'd164,8'd49},
    {8'd254,8'd161,8'd48},{8'd254,8'd158,8'd47},{8'd254,8'd155,8'd45},{8'd254,8'd153,8'd44},
    {8'd254,8'd150,8'd43},{8'd254,8'd147,8'd42},{8'd254,8'd144,8'd41},{8'd253,8'd141,8'd39},
    {8'd253,8'd138,8'd38},{8'd252,8'd135,8'd37},{8'd252,8'd132,8'd35},{8'd251,8'd129,8'd34},
    {8'd251,8'd126,8'd33},{8'd250,8'd123,8'd31},{8'd249,8'd120,8'd30},{8'd249,8'd117,8'd29},
    {8'd248,8'd114,8'd28},{8'd247,8'd111,8'd26},{8'd246,8'd108,8'd25},{8'd245,8'd105,8'd24},
    {8'd244,8'd102,8'd23},{8'd243,8'd99,8'd21},{8'd242,8'd96,8'd20},{8'd241,8'd93,8'd19},
    {8'd240,8'd91,8'd18},{8'd239,8'd88,8'd17},{8'd237,8'd85,8'd16},{8'd236,8'd83,8'd15},
    {8'd235,8'd80,8'd14},{8'd234,8'd78,8'd13},{8'd232,8'd75,8'd12},{8'd231,8'd73,8'd12},
    {8'd229,8'd71,8'd11},{8'd228,8'd69,8'd10},{8'd226,8'd67,8'd10},{8'd225,8'd65,8'd9},
    {8'd223,8'd63,8'd8},{8'd221,8'd61,8'd8},{8'd220,8'd59,8'd7},{8'd218,8'd57,8'd7},
    {8'd216,8'd55,8'd6},{8'd214,8'd53,8'd6},{8'd212,8'd51,8'd5},{8'd210,8'd49,8'd5},
    {8'd208,8'd47,8'd5},{8'd206,8'd45,8'd4},{8'd204,8'd43,8'd4},{8'd202,8'd42,8'd4},
    {8'd200,8'd40,8'd3},{8'd197,8'd38,8'd3},{8'd195,8'd37,8'd3},{8'd193,8'd35,8'd2},
    {8'd190,8'd33,8'd2},{8'd188,8'd32,8'd2},{8'd185,8'd30,8'd2},{8'd183,8'd29,8'd2},
    {8'd180,8'd27,8'd1},{8'd178,8'd26,8'd1},{8'd175,8'd24,8'd1},{8'd172,8'd23,8'd1},
    {8'd169,8'd22,8'd1},{8'd167,8'd20,8'd1},{8'd164,8'd19,8'd1},{8'd161,8'd18,8'd1},
    {8'd158,8'd16,8'd1},{8'd155,8'd15,8'd1},{8'd152,8'd14,8'd1},{8'd149,8'd13,8'd1},
    {8'd146,8'd11,8'd1},{8'd142,8'd10,8'd1},{8'd139,8'd9,8'd2},{8'd136,8'd8,8'd2},
    {8'd133,8'd7,8'd2},{8'd129,8'd6,8'd2},{8'd126,8'd5,8'd2},{8'd122,8'd4,8'd3}
  };

endpackage

>>> rtl/vtc_scale.sv
module vtc_scale (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [vtc_pkg::VEL_W-1:0]     velocity_i,
  input  logic [vtc_pkg::MAXV_W-1:0]    max_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output vtc_pkg::vtc_work_t            work_o
);
  import vtc_pkg::*;

  logic                  valid_q;
  vtc_work_t             work_d, work_q;
  logic [HI_W-1:0]       mag;
  logic [HI_W+IDX_W-1:0] num;
  logic [HI_W-1:0]       hi;

  // v*255 as (v<<8) - v; only used when v is non-negative
  always_comb begin
    mag          = velocity_i[HI_W-1:0];
    num          = {mag, IDX_W'(0)} - (HI_W+IDX_W)'(mag);
    hi           = num[HI_W+IDX_W-1:IDX_W];
    work_d.rem   = MAXV_W'(hi);
    work_d.low   = num[IDX_W-1:0];
    work_d.quo   = '0;
    // quotient of 256 or more clips to the top entry
    work_d.sat   = CMP_W'(hi) >= CMP_W'(max_i);
    work_d.blank = velocity_i[VEL_W-1] || (max_i == '0);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

>>> rtl/vtc_div_step.sv
module vtc_div_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  vtc_pkg::vtc_work_t            work_i,
  input  logic [vtc_pkg::MAXV_W-1:0]    max_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output vtc_pkg::vtc_work_t            work_o
);
  import vtc_pkg::*;

  logic              valid_q;
  vtc_work_t         work_d, work_q;
  logic [MAXV_W:0]   trial;
  logic              ge;

  // restoring division, STEPS_PER_STAGE quotient bits per stage
  always_comb begin
    work_d = work_i;
    trial  = '0;
    ge     = 1'b0;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      trial      = {work_d.rem, work_d.low[IDX_W-1]};
      ge         = trial >= {1'b0, max_i};
      work_d.rem = ge ? MAXV_W'(trial - {1'b0, max_i}) : MAXV_W'(trial);
      work_d.low = {work_d.low[IDX_W-2:0], 1'b0};
      work_d.quo = {work_d.quo[IDX_W-2:0], ge};
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

  // partial remainder stays below the divisor on live, in-range items
  a_rem_below_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !work_q.sat && !work_q.blank |-> work_q.rem < max_i)
    else $error("remainder not reduced below divisor");

endmodule

>>> rtl/vtc_lut.sv
module vtc_lut (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  vtc_pkg::vtc_work_t            work_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output vtc_pkg::vtc_rgb_t             rgb_o
);
  import vtc_pkg::*;

  logic             valid_q;
  vtc_rgb_t         rgb_d, rgb_q;
  logic [IDX_W-1:0] idx;

  always_comb begin
    idx   = work_i.sat ? '1 : work_i.quo;
    rgb_d = work_i.blank ? '0 : TURBO_LUT[idx];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rgb_q <= rgb_d;
    end
  end

  assign valid_o = valid_q;
  assign rgb_o   = rgb_q;

endmodule

>>> rtl/velocity_to_turbo_color.sv
// Pipeline: scale, 4 divider stages, colour lookup; each stage holds one beat.
// Throughput: one beat per cycle unless the sink stalls; beats advance into free stages.
// The divider yields two quotient bits per stage, which sets the depth.
// Reset (async, active low) empties the pipeline and loads max_q with 5.
module velocity_to_turbo_color (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [15:0]                   s_axis_tdata_i,  // [15:0] velocity
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [23:0]                   m_axis_tdata_o,  // [7:0] red, [15:8] green, [23:16] blue
  input  logic                          cfg_we_i,
  input  logic [vtc_pkg::MAXV_W-1:0]    cfg_wdata_i
);
  import vtc_pkg::*;

  logic [MAXV_W-1:0] max_q;
  logic              scale_valid, scale_ready;
  vtc_work_t         scale_work;
  logic              div_valid [DIV_STAGES+1];
  logic              div_ready [DIV_STAGES+1];
  vtc_work_t         div_work  [DIV_STAGES+1];
  vtc_rgb_t          rgb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAXV_RESET;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  vtc_scale u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid_i),
    .ready_o    (s_axis_tready_o),
    .velocity_i (s_axis_tdata_i[VEL_W-1:0]),
    .max_i      (max_q),
    .valid_o    (scale_valid),
    .ready_i    (scale_ready),
    .work_o     (scale_work)
  );

  assign div_valid[0] = scale_valid;
  assign div_work[0]  = scale_work;
  assign scale_ready  = div_ready[0];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    vtc_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_valid[g]),
      .ready_o (div_ready[g]),
      .work_i  (div_work[g]),
      .max_i   (max_q),
      .valid_o (div_valid[g+1]),
      .ready_i (div_ready[g+1]),
      .work_o  (div_work[g+1])
    );
  end

  vtc_lut u_lut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid[DIV_STAGES]),
    .ready_o (div_ready[DIV_STAGES]),
    .work_i  (div_work[DIV_STAGES]),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .rgb_o   (rgb)
  );

  // LUT entry is {r,g,b}; the beat carries red lowest
  assign m_axis_tdata_o = {rgb[COLOR_W-1:0], rgb[2*COLOR_W-1:COLOR_W],
                           rgb[3*COLOR_W-1:2*COLOR_W]};

  // an empty output register lets the whole chain advance
  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with output register empty");

  a_sink_ready_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled while sink is ready");

endmodule

>>> verif/velocity_to_turbo_color_tb.sv
module velocity_to_turbo_color_tb;

  import vtc_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 8;   // a little over the pipeline depth

  // Red in the low byte, as on the output bus
  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } rgb_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [VEL_W-1:0]  s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [23:0]       m_tdata;
  logic              cfg_we = 1'b0;
  logic [MAXV_W-1:0] cfg_wdata = '0;

  logic [VEL_W-1:0]  pending_vel[$];
  rgb_t              colour_due[$];
  logic [MAXV_W-1:0] max_vel = MAXV_RESET;

  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int errors = 0;
  int samples_in = 0;
  int colours_out = 0;
  int settings_used = 1;
  int quiet_cycles = 0;

  rgb_t got;
  rgb_t want;

  velocity_to_turbo_color u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic rgb_t turbo_colour(logic [VEL_W-1:0] vel, logic [MAXV_W-1:0] maxv);
    int unsigned mag;
    int unsigned div;
    int unsigned idx;
    vtc_rgb_t    entry;
    rgb_t        c;
    c = '0;
    if (!vel[VEL_W-1] && maxv != '0) begin
      mag = 32'(vel[VEL_W-2:0]);
      div = 32'(maxv);
      idx = (mag * 255) / div;
      if (idx > 255) idx = 255;
      entry = TURBO_LUT[idx[IDX_W-1:0]];
      c.red   = entry[23:16];
      c.green = entry[15:8];
      c.blue  = entry[7:0];
    end
    return c;
  endfunction

  function automatic logic [VEL_W-1:0] rand_velocity(logic [MAXV_W-1:0] maxv);
    logic [VEL_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = VEL_W'($urandom_range(maxv, 0));
      4, 5:       v = VEL_W'($urandom_range(32767, maxv));
      6, 7:       v = 16'h8000 | VEL_W'($urandom_range(32767, 0));
      default:    v = VEL_W'($urandom);
    endcase
    return v;
  endfunction

  // Sender: one beat held until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_vel.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        s_tdata  <= pending_vel.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Predict on input beats, check on output beats, watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (s_tvalid && s_tready) begin
        colour_due.push_back(turbo_colour(s_tdata, max_vel));
        samples_in++;
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        colours_out++;
        if (colour_due.size() == 0) begin
          $display("%0t: unexpected colour beat r=%0d g=%0d b=%0d",
                   $time, got.red, got.green, got.blue);
          errors++;
        end else begin
          want = colour_due.pop_front();
          if (got.red != want.red) begin
            $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
            errors++;
          end
          if (got.green != want.green) begin
            $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
            errors++;
          end
          if (got.blue != want.blue) begin
            $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
            errors++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d colours outstanding",
                 $time, STALL_LIMIT, colour_due.size());
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic drain();
    do @(negedge clk);
    while (pending_vel.size() != 0 || s_tvalid || colour_due.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic set_max(logic [MAXV_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_vel = v;
    settings_used++;
    @(negedge clk);
  endtask

  initial begin
    int ph;
    int n;
    int mode;
    logic [MAXV_W-1:0] setting;

    // ends of the table against the known Turbo colours
    if (TURBO_LUT[0] != {8'd48, 8'd18, 8'd59} || TURBO_LUT[255] != {8'd122, 8'd4, 8'd3}) begin
      $display("%0t: colour table ends expected 48/18/59 and 122/4/3 actual %h and %h",
               $time, TURBO_LUT[0], TURBO_LUT[255]);
      errors++;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset maximum of 5: small steps, saturation, sign
    pending_vel.push_back(16'd0);
    pending_vel.push_back(16'd1);
    pending_vel.push_back(16'd2);
    pending_vel.push_back(16'd4);
    pending_vel.push_back(16'd5);
    pending_vel.push_back(16'd6);
    pending_vel.push_back(16'h7FFF);
    pending_vel.push_back(16'hFFFF);
    pending_vel.push_back(16'h8000);
    drain();

    set_max(15'h7FFF);
    pending_vel.push_back(16'd0);
    pending_vel.push_back(16'd128);
    pending_vel.push_back(16'd129);
    pending_vel.push_back(16'd32766);
    pending_vel.push_back(16'h7FFF);
    pending_vel.push_back(16'h8000);
    pending_vel.push_back(16'hFFFF);
    drain();

    // zero maximum blanks everything
    set_max(15'd0);
    pending_vel.push_back(16'd0);
    pending_vel.push_back(16'd1);
    pending_vel.push_back(16'h7FFF);
    pending_vel.push_back(16'hFFFF);
    drain();

    set_max(15'd1);
    pending_vel.push_back(16'd0);
    pending_vel.push_back(16'd1);
    pending_vel.push_back(16'd2);
    drain();

    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0:       setting = 15'd255;
        1:       setting = 15'h7FFF;
        2:       setting = 15'd1000;
        4:       setting = 15'd1;
        5:       setting = 15'd0;
        default: setting = MAXV_W'($urandom_range(32767, 1));
      endcase
      set_max(setting);
      mode = ph % 4;
      src_idle_pct   = (mode == 1) ? 61 : (mode == 3) ? 22 : 0;
      sink_stall_pct = (mode == 2) ? 61 : (mode == 3) ? 22 : 0;
      // no idling here, so the sender keeps offering while the output is held
      if (ph == 4) hold_req = hold_req + 1;
      for (n = 0; n < 70; n++) begin
        pending_vel.push_back(rand_velocity(setting));
        // sender pauses mid-phase until the pipeline is empty
        if (ph == 2 && n == 34) drain();
      end
      drain();
    end

    $display("%0d velocity samples mapped under %0d maximum settings, %0d colours checked",
             samples_in, settings_used, colours_out);
    $display("idling phases: none, sender, receiver, both; one long output hold-off");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
